@@ rtl/rbs_pkg.sv @@
`timescale 1ns / 1ps
package rbs_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_BOX_MIN_X    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOX_MIN_Y    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOX_MIN_Z    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BOX_MAX_X    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BOX_MAX_Y    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BOX_MAX_Z    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DISTANCE = 3'd6;

  // Face codes
  localparam logic [2:0] FACE_NEG_X = 3'd0;
  localparam logic [2:0] FACE_NEG_Y = 3'd1;
  localparam logic [2:0] FACE_NEG_Z = 3'd2;
  localparam logic [2:0] FACE_POS_X = 3'd3;
  localparam logic [2:0] FACE_POS_Y = 3'd4;
  localparam logic [2:0] FACE_POS_Z = 3'd5;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic [2:0]         face;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } hit_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic [30:0]        min_distance;
  } box_cfg_t;

  // Classified ray handed from the front to the back, indexed by axis
  typedef struct packed {
    logic             miss;
    logic [2:0]       par;
    logic [2:0]       dneg;
    logic [2:0]       neg_lo;
    logic [2:0]       neg_hi;
    logic [2:0][31:0] mag_lo;
    logic [2:0][31:0] mag_hi;
    logic [2:0][31:0] dmag;
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
  } slab_job_t;

endpackage

@@ rtl/rbs_front.sv @@
`timescale 1ns / 1ps
module rbs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rbs_pkg::ray_t     in_data_i,
  input  rbs_pkg::box_cfg_t box_i,
  input  logic              full_i,
  output logic              push_o,
  output rbs_pkg::slab_job_t job_o
);

  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [32:0] dlo [3];
  logic signed [32:0] dhi [3];
  logic [2:0]         outside;
  rbs_pkg::slab_job_t job_d, job_q;
  logic               valid_q;

  always_comb begin
    lo[0] = box_i.box_min_x; lo[1] = box_i.box_min_y; lo[2] = box_i.box_min_z;
    hi[0] = box_i.box_max_x; hi[1] = box_i.box_max_y; hi[2] = box_i.box_max_z;
    org[0] = in_data_i.origin_x; org[1] = in_data_i.origin_y; org[2] = in_data_i.origin_z;
    dir[0] = in_data_i.dir_x; dir[1] = in_data_i.dir_y; dir[2] = in_data_i.dir_z;
    job_d = '0;
    for (int a = 0; a < 3; a++) begin
      dlo[a] = {lo[a][31], lo[a]} - {org[a][31], org[a]};
      dhi[a] = {hi[a][31], hi[a]} - {org[a][31], org[a]};
      outside[a] = (org[a] < lo[a]) || (org[a] > hi[a]);
      job_d.par[a] = (dir[a] == 32'sd0);
      job_d.dneg[a] = dir[a][31];
      job_d.neg_lo[a] = dlo[a][32];
      job_d.neg_hi[a] = dhi[a][32];
      job_d.mag_lo[a] = dlo[a][32] ? 32'(-dlo[a]) : dlo[a][31:0];
      job_d.mag_hi[a] = dhi[a][32] ? 32'(-dhi[a]) : dhi[a][31:0];
      job_d.dmag[a] = dir[a][31] ? 32'(-dir[a]) : dir[a];
      job_d.org[a] = org[a];
      job_d.dir[a] = dir[a];
    end
    // parallel axis with the origin outside its slab: a miss
    job_d.miss = |(job_d.par & outside);
  end

  assign in_stall_o = valid_q & full_i;
  assign push_o     = valid_q & ~full_i;
  assign job_o      = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

@@ rtl/rbs_queue.sv @@
`timescale 1ns / 1ps
module rbs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rbs_pkg::slab_job_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rbs_pkg::slab_job_t data_o
);

  localparam int unsigned PtrW = $clog2(rbs_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(rbs_pkg::QueueDepth + 1);

  rbs_pkg::slab_job_t mem_q [rbs_pkg::QueueDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]    cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(rbs_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PtrW'(1);
      if (do_pop) rd_q <= rd_q + PtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/rbs_div.sv @@
`timescale 1ns / 1ps
module rbs_div #(
  parameter int unsigned QW = 48
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] num_i,
  input  logic [31:0]   den_i,
  output logic [QW-1:0] quo_o
);

  logic [31:0]   rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] num_q [QW];
  logic [31:0]   den_q [QW];

  // one quotient bit per stage, restoring
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [31:0]   r_in;
    logic [QW-1:0] q_in;
    logic [QW-1:0] n_in;
    logic [31:0]   d_in;
    logic [32:0]   trial;
    logic          ge;
    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = num_i;
      assign d_in = den_i;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign q_in = quo_q[s-1];
      assign n_in = num_q[s-1];
      assign d_in = den_q[s-1];
    end
    assign trial = {r_in, n_in[QW-1]};
    assign ge    = (trial >= {1'b0, d_in});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? 32'(trial - {1'b0, d_in}) : trial[31:0];
        quo_q[s] <= {q_in[QW-2:0], ge};
        num_q[s] <= n_in << 1;
        den_q[s] <= d_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

@@ rtl/rbs_back.sv @@
`timescale 1ns / 1ps
module rbs_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  rbs_pkg::slab_job_t job_i,
  output logic               pop_o,
  input  logic [30:0]        eps_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbs_pkg::hit_t      out_data_o
);

  localparam int unsigned QW = 32 + FRAC_BITS;
  localparam int unsigned TW = 34 + FRAC_BITS;
  localparam logic signed [TW-1:0] Unb  = {2'b01, {(32 + FRAC_BITS){1'b0}}};
  localparam logic signed [TW-1:0] TMax = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] TMin = TW'(-64'sd2147483648);
  localparam logic signed [64:0]   PMax = 65'sd2147483647;
  localparam logic signed [64:0]   PMin = -65'sd2147483648;

  typedef struct packed {
    logic             miss;
    logic [2:0]       par;
    logic [2:0]       dneg;
    logic [2:0]       qneg_lo;
    logic [2:0]       qneg_hi;
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
  } side_t;

  logic          en;
  side_t         side_in;
  side_t         side_q [QW];
  logic [QW-1:0] vld_q;
  logic [QW-1:0] quo_lo [3];
  logic [QW-1:0] quo_hi [3];

  assign en    = ~out_valid_o | ~out_stall_i;
  assign pop_o = en & job_valid_i;

  always_comb begin
    side_in.miss    = job_i.miss;
    side_in.par     = job_i.par;
    side_in.dneg    = job_i.dneg;
    side_in.qneg_lo = job_i.neg_lo ^ job_i.dneg;
    side_in.qneg_hi = job_i.neg_hi ^ job_i.dneg;
    side_in.org     = job_i.org;
    side_in.dir     = job_i.dir;
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_div #(.QW(QW)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({job_i.mag_lo[a], {FRAC_BITS{1'b0}}}),
      .den_i (job_i.dmag[a]),
      .quo_o (quo_lo[a])
    );
    rbs_div #(.QW(QW)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({job_i.mag_hi[a], {FRAC_BITS{1'b0}}}),
      .den_i (job_i.dmag[a]),
      .quo_o (quo_hi[a])
    );
  end

  // side information travels alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QW-2:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int s = 1; s < QW; s++) side_q[s] <= side_q[s-1];
    end
  end

  // stage 1: signed slab distances
  logic signed [TW-1:0] s1_tmin_d [3], s1_tmax_d [3];
  logic signed [TW-1:0] s1_tmin_q [3], s1_tmax_q [3];
  logic signed [TW-1:0] qlo, qhi;
  side_t                s1_side_q, s2_side_q, s3_side_q;
  logic                 v1_q, v2_q, v3_q, v4_q, v5_q;

  always_comb begin
    qlo = '0;
    qhi = '0;
    for (int a = 0; a < 3; a++) begin
      qlo = TW'(quo_lo[a]);
      qhi = TW'(quo_hi[a]);
      if (side_q[QW-1].qneg_lo[a]) qlo = -qlo;
      if (side_q[QW-1].qneg_hi[a]) qhi = -qhi;
      if (side_q[QW-1].par[a]) begin
        s1_tmin_d[a] = -Unb;
        s1_tmax_d[a] = Unb;
      end else if (side_q[QW-1].dneg[a]) begin
        s1_tmin_d[a] = qhi;
        s1_tmax_d[a] = qlo;
      end else begin
        s1_tmin_d[a] = qlo;
        s1_tmax_d[a] = qhi;
      end
    end
  end

  // stage 2: x against y
  logic signed [TW-1:0] s2_t0_q, s2_t1_q, s2_tmin_z_q, s2_tmax_z_q;
  logic [2:0]           s2_fin_q, s2_fout_q;
  // stage 3: z against the x/y pick
  logic signed [TW-1:0] s3_t0_q, s3_t1_q;
  logic [2:0]           s3_fin_q, s3_fout_q;
  // stage 4: decide and saturate
  logic signed [TW-1:0] epsx, s4_tsel;
  logic                 s4_hit_d;
  logic [2:0]           s4_face_d;
  logic                 s4_hit_q;
  logic signed [31:0]   s4_t_q;
  logic [2:0]           s4_face_q;
  logic signed [31:0]   s4_org_q [3], s4_dir_q [3];
  // stage 5: products
  logic                 s5_hit_q;
  logic signed [31:0]   s5_t_q;
  logic [2:0]           s5_face_q;
  logic signed [31:0]   s5_org_q [3];
  logic signed [63:0]   s5_prod_q [3];
  // output
  logic signed [63:0]   sh [3];
  logic signed [64:0]   sum [3];
  logic signed [31:0]   pt [3];
  rbs_pkg::hit_t        out_d, out_q;
  logic                 out_valid_q;

  always_comb begin
    epsx = TW'({1'b0, eps_i});
    s4_hit_d = ~s3_side_q.miss && (s3_t0_q < s3_t1_q) && (s3_t1_q > epsx);
    if (s3_t0_q > epsx) begin
      s4_tsel   = s3_t0_q;
      s4_face_d = s3_fin_q;
    end else begin
      s4_tsel   = s3_t1_q;
      s4_face_d = s3_fout_q;
    end
  end

  always_comb begin
    out_d = '0;
    for (int a = 0; a < 3; a++) begin
      sh[a]  = s5_prod_q[a] >>> FRAC_BITS;
      sum[a] = {sh[a][63], sh[a]} + 65'(s5_org_q[a]);
      if (sum[a] > PMax) pt[a] = 32'sh7fffffff;
      else if (sum[a] < PMin) pt[a] = 32'sh80000000;
      else pt[a] = sum[a][31:0];
    end
    if (s5_hit_q) begin
      out_d.hit          = 1'b1;
      out_d.hit_distance = s5_t_q;
      out_d.face         = s5_face_q;
      out_d.point_x      = pt[0];
      out_d.point_y      = pt[1];
      out_d.point_z      = pt[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= vld_q[QW-1];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_tmin_q <= s1_tmin_d;
      s1_tmax_q <= s1_tmax_d;
      s1_side_q <= side_q[QW-1];

      if (s1_tmin_q[0] > s1_tmin_q[1]) begin
        s2_t0_q  <= s1_tmin_q[0];
        s2_fin_q <= s1_side_q.dneg[0] ? rbs_pkg::FACE_POS_X : rbs_pkg::FACE_NEG_X;
      end else begin
        s2_t0_q  <= s1_tmin_q[1];
        s2_fin_q <= s1_side_q.dneg[1] ? rbs_pkg::FACE_POS_Y : rbs_pkg::FACE_NEG_Y;
      end
      if (s1_tmax_q[0] < s1_tmax_q[1]) begin
        s2_t1_q   <= s1_tmax_q[0];
        s2_fout_q <= s1_side_q.dneg[0] ? rbs_pkg::FACE_NEG_X : rbs_pkg::FACE_POS_X;
      end else begin
        s2_t1_q   <= s1_tmax_q[1];
        s2_fout_q <= s1_side_q.dneg[1] ? rbs_pkg::FACE_NEG_Y : rbs_pkg::FACE_POS_Y;
      end
      s2_tmin_z_q <= s1_tmin_q[2];
      s2_tmax_z_q <= s1_tmax_q[2];
      s2_side_q   <= s1_side_q;

      if (s2_tmin_z_q > s2_t0_q) begin
        s3_t0_q  <= s2_tmin_z_q;
        s3_fin_q <= s2_side_q.dneg[2] ? rbs_pkg::FACE_POS_Z : rbs_pkg::FACE_NEG_Z;
      end else begin
        s3_t0_q  <= s2_t0_q;
        s3_fin_q <= s2_fin_q;
      end
      if (s2_tmax_z_q < s2_t1_q) begin
        s3_t1_q   <= s2_tmax_z_q;
        s3_fout_q <= s2_side_q.dneg[2] ? rbs_pkg::FACE_NEG_Z : rbs_pkg::FACE_POS_Z;
      end else begin
        s3_t1_q   <= s2_t1_q;
        s3_fout_q <= s2_fout_q;
      end
      s3_side_q <= s2_side_q;

      s4_hit_q  <= s4_hit_d;
      s4_face_q <= s4_face_d;
      if (s4_tsel > TMax) s4_t_q <= 32'sh7fffffff;
      else if (s4_tsel < TMin) s4_t_q <= 32'sh80000000;
      else s4_t_q <= s4_tsel[31:0];
      for (int a = 0; a < 3; a++) begin
        s4_org_q[a] <= s3_side_q.org[a];
        s4_dir_q[a] <= s3_side_q.dir[a];
      end

      s5_hit_q  <= s4_hit_q;
      s5_t_q    <= s4_t_q;
      s5_face_q <= s4_face_q;
      for (int a = 0; a < 3; a++) begin
        s5_org_q[a]  <= s4_org_q[a];
        s5_prod_q[a] <= s4_t_q * s4_dir_q[a];
      end

      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps
// Ray against axis-aligned box, slab method, signed fixed point with
// FRAC_BITS fraction bits.
// Input channel: one ray (origin, direction) per transfer on in_valid_i /
// in_stall_o / in_data_i. Output channel: one result per ray, in order, on
// out_valid_o / out_stall_i / out_data_o. A transfer happens on a rising
// edge with valid high and stall low.
// Box corners and min_distance sit in a plain write port (cfg_we_i,
// cfg_idx_i, cfg_wdata_i); write them only while no ray is in flight.
// Throughput: one ray per cycle while the output is not stalled. Path from
// input transfer to output valid: front register, queue, one divider stage
// per quotient bit, then select, multiply and point stages.
// The front classifies rays into a four-entry queue; the back pipeline
// advances as a whole and holds while the output register is stalled, so
// the queue then fills and the input stall rises.
// Reset clears all valid flags and loads the box to the unit cube with
// min_distance 66; no results are pending after reset.
module ray_box_slab_intersect #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rbs_pkg::ray_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rbs_pkg::hit_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [rbs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i
);

  rbs_pkg::box_cfg_t  box_q;
  rbs_pkg::slab_job_t front_job, queue_job;
  logic               push, full, queue_valid, pop;

  // hold configuration; ignore writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q.box_min_x    <= 32'sd0;
      box_q.box_min_y    <= 32'sd0;
      box_q.box_min_z    <= 32'sd0;
      box_q.box_max_x    <= 32'sd65536;
      box_q.box_max_y    <= 32'sd65536;
      box_q.box_max_z    <= 32'sd65536;
      box_q.min_distance <= 31'd66;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbs_pkg::CFG_BOX_MIN_X:    box_q.box_min_x    <= cfg_wdata_i;
        rbs_pkg::CFG_BOX_MIN_Y:    box_q.box_min_y    <= cfg_wdata_i;
        rbs_pkg::CFG_BOX_MIN_Z:    box_q.box_min_z    <= cfg_wdata_i;
        rbs_pkg::CFG_BOX_MAX_X:    box_q.box_max_x    <= cfg_wdata_i;
        rbs_pkg::CFG_BOX_MAX_Y:    box_q.box_max_y    <= cfg_wdata_i;
        rbs_pkg::CFG_BOX_MAX_Z:    box_q.box_max_z    <= cfg_wdata_i;
        rbs_pkg::CFG_MIN_DISTANCE: box_q.min_distance <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // front: differences, magnitudes, parallel-axis test
  rbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .box_i      (box_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (front_job)
  );

  // short queue so front and back stall independently
  rbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .data_o  (queue_job)
  );

  // back: pipelined division, slab selection, hit point
  rbs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_i       (queue_job),
    .pop_o       (pop),
    .eps_i       (box_q.min_distance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned Frac = 16;
  localparam int unsigned Latency = 32 + Frac + 7;
  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;
  localparam longint Unbounded = 64'sh4000000000000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rbs_pkg::ray_t in_data;
  logic        out_valid;
  logic        out_stall;
  rbs_pkg::hit_t out_data;
  logic        cfg_we;
  logic [rbs_pkg::CfgIdxW-1:0] cfg_idx;
  logic [31:0] cfg_wdata;

  ray_box_slab_intersect #(.FRAC_BITS(Frac)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor's own copy of the box registers
  longint box_lo [3];
  longint box_hi [3];
  longint eps;

  rbs_pkg::ray_t ray_queue [$];
  rbs_pkg::hit_t hit_queue [$];
  int     errors;
  bit     driver_hold;   // pause the sender between phases
  bit     long_stall;    // receiver holds off for a long stretch

  function automatic longint floor_q(longint p);
    return p >>> Frac;   // arithmetic shift rounds toward minus infinity
  endfunction

  function automatic longint clamp32(longint v);
    if (v > SatMax) return SatMax;
    if (v < SatMin) return SatMin;
    return v;
  endfunction

  // Slab intersection of one ray with the box
  function automatic rbs_pkg::hit_t intersect_ray(rbs_pkg::ray_t r);
    rbs_pkg::hit_t h;
    longint org [3];
    longint dv [3];
    longint tlo [3];
    longint thi [3];
    longint a, b, t0, t1, t;
    logic [2:0] fin, fout, fc;
    bit     ok;
    ok = 1'b1;
    h = '0;
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dv[0] = r.dir_x; dv[1] = r.dir_y; dv[2] = r.dir_z;
    for (int i = 0; i < 3; i++) begin
      if (dv[i] == 0) begin
        if (org[i] < box_lo[i] || org[i] > box_hi[i]) ok = 1'b0;
        tlo[i] = -Unbounded;
        thi[i] = Unbounded;
      end else begin
        a = ((box_lo[i] - org[i]) * (64'sd1 << Frac)) / dv[i];
        b = ((box_hi[i] - org[i]) * (64'sd1 << Frac)) / dv[i];
        if (dv[i] < 0) begin
          tlo[i] = b; thi[i] = a;
        end else begin
          tlo[i] = a; thi[i] = b;
        end
      end
    end
    if (!ok) return h;
    if (tlo[0] > tlo[1]) begin
      t0 = tlo[0]; fin = dv[0] >= 0 ? rbs_pkg::FACE_NEG_X : rbs_pkg::FACE_POS_X;
    end else begin
      t0 = tlo[1]; fin = dv[1] >= 0 ? rbs_pkg::FACE_NEG_Y : rbs_pkg::FACE_POS_Y;
    end
    if (tlo[2] > t0) begin
      t0 = tlo[2]; fin = dv[2] >= 0 ? rbs_pkg::FACE_NEG_Z : rbs_pkg::FACE_POS_Z;
    end
    if (thi[0] < thi[1]) begin
      t1 = thi[0]; fout = dv[0] >= 0 ? rbs_pkg::FACE_POS_X : rbs_pkg::FACE_NEG_X;
    end else begin
      t1 = thi[1]; fout = dv[1] >= 0 ? rbs_pkg::FACE_POS_Y : rbs_pkg::FACE_NEG_Y;
    end
    if (thi[2] < t1) begin
      t1 = thi[2]; fout = dv[2] >= 0 ? rbs_pkg::FACE_POS_Z : rbs_pkg::FACE_NEG_Z;
    end
    if (!(t0 < t1 && t1 > eps)) return h;
    if (t0 > eps) begin
      t = t0; fc = fin;
    end else begin
      t = t1; fc = fout;
    end
    t = clamp32(t);
    h.hit = 1'b1;
    h.hit_distance = t[31:0];
    h.face = fc;
    h.point_x = 32'(clamp32(org[0] + floor_q(t * dv[0])));
    h.point_y = 32'(clamp32(org[1] + floor_q(t * dv[1])));
    h.point_z = 32'(clamp32(org[2] + floor_q(t * dv[2])));
    return h;
  endfunction

  // Driver: bursts of transfers with random gaps between them
  int burst_left;
  int gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      // previous transfer done (or none offered): choose the next one
      if (in_valid) hit_queue.push_back(intersect_ray(in_data));
      if (ray_queue.size() == 0 || driver_hold) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= ray_queue.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver stall pattern: runs of free cycles and runs of random stalls of varied density
  int stall_run;
  int stall_mode;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
      stall_mode <= 0;
    end else if (long_stall) begin
      out_stall <= 1'b1;
    end else if (stall_run == 0) begin
      stall_run <= $urandom_range(1, 30);
      stall_mode <= $urandom_range(0, 3);
      out_stall <= 1'b0;
    end else begin
      stall_run <= stall_run - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hit_queue.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, out_data);
        errors++;
      end else begin
        rbs_pkg::hit_t exp_h;
        exp_h = hit_queue.pop_front();
        if (out_data.hit !== exp_h.hit ||
            out_data.hit_distance !== exp_h.hit_distance ||
            out_data.face !== exp_h.face ||
            out_data.point_x !== exp_h.point_x ||
            out_data.point_y !== exp_h.point_y ||
            out_data.point_z !== exp_h.point_z) begin
          $display("%0t mismatch: expected %p actual %p", $time, exp_h, out_data);
          errors++;
        end
      end
    end
  end

  // Write one box register and mirror it in the predictor
  task automatic write_reg(logic [rbs_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx) inside
      rbs_pkg::CFG_BOX_MIN_X, rbs_pkg::CFG_BOX_MIN_Y, rbs_pkg::CFG_BOX_MIN_Z:
        box_lo[idx] = longint'($signed(val));
      rbs_pkg::CFG_BOX_MAX_X, rbs_pkg::CFG_BOX_MAX_Y, rbs_pkg::CFG_BOX_MAX_Z:
        box_hi[idx - rbs_pkg::CFG_BOX_MAX_X] = longint'($signed(val));
      rbs_pkg::CFG_MIN_DISTANCE: eps = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                         logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                         logic [31:0] e);
    write_reg(rbs_pkg::CFG_BOX_MIN_X, lx);
    write_reg(rbs_pkg::CFG_BOX_MIN_Y, ly);
    write_reg(rbs_pkg::CFG_BOX_MIN_Z, lz);
    write_reg(rbs_pkg::CFG_BOX_MAX_X, hx);
    write_reg(rbs_pkg::CFG_BOX_MAX_Y, hy);
    write_reg(rbs_pkg::CFG_BOX_MAX_Z, hz);
    write_reg(rbs_pkg::CFG_MIN_DISTANCE, e);
  endtask

  // Wait for the pipe to drain, then settle
  task automatic drain();
    wait (ray_queue.size() == 0 && !in_valid);
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int scale);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 2) == 0 ? 32'h0 : 32'h7fffffff;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2 * scale)) - scale);
    endcase
  endfunction

  function automatic rbs_pkg::ray_t rand_ray(int scale);
    rbs_pkg::ray_t r;
    r.origin_x = rand_coord(scale);
    r.origin_y = rand_coord(scale);
    r.origin_z = rand_coord(scale);
    r.dir_x = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord(scale);
    r.dir_y = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord(scale);
    r.dir_z = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord(scale);
    return r;
  endfunction

  // Aim a ray from a nearby origin at a point inside the box
  function automatic rbs_pkg::ray_t aimed_ray();
    rbs_pkg::ray_t r;
    longint tx, ty, tz;
    tx = box_lo[0] + (box_hi[0] - box_lo[0]) * $urandom_range(0, 100) / 100;
    ty = box_lo[1] + (box_hi[1] - box_lo[1]) * $urandom_range(0, 100) / 100;
    tz = box_lo[2] + (box_hi[2] - box_lo[2]) * $urandom_range(0, 100) / 100;
    r.origin_x = 32'(clamp32(tx + $signed($urandom_range(0, 1 << 20)) - (1 << 19)));
    r.origin_y = 32'(clamp32(ty + $signed($urandom_range(0, 1 << 20)) - (1 << 19)));
    r.origin_z = 32'(clamp32(tz + $signed($urandom_range(0, 1 << 20)) - (1 << 19)));
    r.dir_x = 32'(clamp32(tx - longint'(r.origin_x)));
    r.dir_y = 32'(clamp32(ty - longint'(r.origin_y)));
    r.dir_z = 32'(clamp32(tz - longint'(r.origin_z)));
    return r;
  endfunction

  function automatic rbs_pkg::ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
    rbs_pkg::ray_t r;
    r = '{ox, oy, oz, dx, dy, dz};
    return r;
  endfunction

  initial begin
    errors = 0;
    driver_hold = 1'b0;
    long_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = rbs_pkg::CFG_BOX_MIN_X;
    cfg_wdata = '0;
    box_lo = '{0, 0, 0};
    box_hi = '{65536, 65536, 65536};
    eps = 66;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays against the reset unit cube
    ray_queue.push_back(mk(-65536, 32768, 32768, 65536, 0, 0));     // -X entry
    ray_queue.push_back(mk(32768, -65536, 32768, 0, 65536, 0));     // -Y entry
    ray_queue.push_back(mk(32768, 32768, 131072, 0, 0, -65536));    // +Z entry
    ray_queue.push_back(mk(32768, 32768, 32768, 65536, 0, 0));      // inside: exit face
    ray_queue.push_back(mk(32768, 32768, 32768, 0, 0, 0));          // all zero, inside
    ray_queue.push_back(mk(131072, 32768, 32768, 0, 0, 0));         // all zero, outside
    ray_queue.push_back(mk(65536, 65536, 65536, 0, 0, 0));          // corner, bounds inclusive
    ray_queue.push_back(mk(-65536, -65536, 32768, 65536, 65536, 0)); // x/y tie
    ray_queue.push_back(mk(-65536, -65536, -65536, 65536, 65536, 65536)); // 3-way tie
    ray_queue.push_back(mk(131072, 131072, 131072, -65536, -65536, -65536));
    ray_queue.push_back(mk(-65536, 32768, 32768, -65536, 0, 0));    // pointing away
    ray_queue.push_back(mk(0, 32768, 32768, 65536, 0, 0));          // origin on face
    ray_queue.push_back(mk(-2147483648, 32768, 32768, 1, 0, 0));    // saturated distance
    ray_queue.push_back(mk(2147483647, 2147483647, 2147483647,
                           -2147483648, -2147483648, -2147483648));
    ray_queue.push_back(mk(-2147483648, -2147483648, -2147483648,
                           2147483647, 2147483647, 2147483647));
    ray_queue.push_back(mk(32768, 32768, 32768, -1, -1, -1));
    ray_queue.push_back(mk(-1, 32768, 32768, 2147483647, 0, 0));
    ray_queue.push_back(mk(32768, 32768, 32768, 2147483647, -2147483648, 1));
    drain();

    // Inverted box, extreme min_distance
    set_box(32'h00020000, 32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h00010000,
            32'h7fffffff);
    ray_queue.push_back(mk(-65536, 32768, 32768, 65536, 0, 0));
    ray_queue.push_back(mk(32768, 32768, 32768, 65536, 65536, 0));
    drain();
    set_box(32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
    for (int i = 0; i < 10; i++) ray_queue.push_back(rand_ray(1 << 20));
    drain();

    // Random phases with varied boxes; long receiver hold in one phase
    for (int ph = 0; ph < 6; ph++) begin
      longint c, s;
      c = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      s = $urandom_range(1, 1 << 20);
      set_box(32'(c - s), 32'(c - s / 2), 32'(c - 2 * s),
              32'(c + s), 32'(c + s), 32'(c + s / 3),
              (ph == 5) ? 32'hffffffff : $urandom_range(0, 1 << 14));
      for (int i = 0; i < 85; i++)
        ray_queue.push_back(($urandom_range(0, 3) != 0) ? aimed_ray()
                                                         : rand_ray(1 << 22));
      if (ph == 2) begin
        long_stall = 1'b1;
        repeat (200) @(posedge clk);
        long_stall = 1'b0;
      end
      if (ph == 3) begin
        // pause the sender until every expectation is met
        wait (ray_queue.size() < 40);
        driver_hold = 1'b1;
        while (in_valid) @(posedge clk);
        while (hit_queue.size() != 0) @(posedge clk);
        driver_hold = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rbs_pkg.sv
rtl/rbs_front.sv
rtl/rbs_queue.sv
rtl/rbs_div.sv
rtl/rbs_back.sv
rtl/ray_box_slab_intersect.sv
sim/testbench.sv
